FILE: sv/lob_pkg.sv
// Package for the limit order book matcher: payload structs, codes, constants.
// No dependencies; every module of the block but lob_ram imports it.
`default_nettype none
package lob_pkg;
  localparam int BookDepthDef = 32;

  localparam logic [1:0] KIND_SELL = 2'd0;
  localparam logic [1:0] KIND_BUY  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_SKIP = 2'd3;

  localparam logic [2:0] RES_FILL    = 3'd0;
  localparam logic [2:0] RES_RESTED  = 3'd1;
  localparam logic [2:0] RES_FILLED  = 3'd2;
  localparam logic [2:0] RES_DROPPED = 3'd3;
  localparam logic [2:0] RES_TICK    = 3'd4;

  localparam logic [16:0] DECAY_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] price;
    logic [15:0] amount;
    logic [9:0]  trader_id;
    logic [31:0] precedence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [23:0] fill_price;
    logic [15:0] fill_amount;
    logic [9:0]  buy_trader;
    logic [9:0]  sell_trader;
    logic [39:0] payback;
    logic        last;
    logic [23:0] recent_price;
    logic [23:0] low_price;
    logic [23:0] high_price;
    logic [47:0] traded_volume;
    logic [63:0] traded_value;
  } out_item_t;

  // One book entry as stored in memory.
  typedef struct packed {
    logic [23:0] price;
    logic [31:0] seq;
    logic [15:0] qty;
    logic [9:0]  owner;
  } entry_t;

  localparam int EntryW = $bits(entry_t);
endpackage
`default_nettype wire

FILE: sv/lob_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lob_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer, statistics, book RAMs.
// Depends on lob_pkg and lob_ram.
//
// One transaction is accepted when start is high and busy is low; results
// leave one per cycle on out_valid and cannot be held off. Each side of the
// book lives in one RAM (price, sequence, quantity, owner per entry) with a
// registered read; valid bits sit in flip-flops. An order runs a best-entry
// scan per fill: the scan reads every slot of the opposite side through the
// RAM port, S_EVAL waits for the last compare to land, S_RDB judges the best
// entry, then S_FILL writes the fill back. A tick sweeps the sell RAM
// read-modify-write, S_TICKR reading and S_TICKW writing each slot; a tick
// with no decay and an order of zero amount go straight to the summary. The
// summary result shows in the first cycle that busy is low again. No clearing
// pass is needed after reset.
`default_nettype none
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = lob_pkg::BookDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire lob_pkg::in_item_t  in_item,
  output      logic               out_valid,
  output      lob_pkg::out_item_t out_item,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_wdata
);
  import lob_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_RDB   = 9'b000001000,
    S_FILL  = 9'b000010000,
    S_INS   = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_TICKR = 9'b010000000,
    S_TICKW = 9'b100000000
  } state_t;

  // Per-result fields held in a register; statistics are added on the way out.
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [23:0] fill_price;
    logic [15:0] fill_amount;
    logic [9:0]  buy_trader;
    logic [9:0]  sell_trader;
    logic [39:0] payback;
    logic        last;
  } head_t;

  state_t state_r, state_nxt;

  logic [16:0] decay_r;
  in_item_t    item_r;
  logic [31:0] seq_r, counter_r;
  logic [15:0] left_r;
  logic [BOOK_DEPTH-1:0] sv_r, bv_r;
  head_t       res_r;

  // Scan bookkeeping: issue counter, compare counter (registered copy of the issue index).
  logic [CW-1:0] idx_r;
  logic [AW-1:0] cmp_idx_r;
  logic          cmp_act_r;
  logic          found_r;
  logic [AW-1:0] best_r;
  entry_t        best_e_r;
  logic [2:0]    sum_kind_r;

  // Statistics.
  logic [23:0] recent_r, min_r, max_r;
  logic [47:0] vol_r;
  logic [63:0] val_r;

  // RAM ports.
  logic          s_we, b_we;
  logic [AW-1:0] raddr, waddr;
  entry_t        wdata, s_rd, b_rd, rd;

  lob_ram #(.Width(EntryW), .Depth(BOOK_DEPTH)) u_sell (
    .clk(clk), .we(s_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(s_rd));
  lob_ram #(.Width(EntryW), .Depth(BOOK_DEPTH)) u_buy (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(b_rd));

  logic is_buy;
  assign is_buy = (item_r.kind == KIND_BUY);
  // Opposite side is scanned for matching.
  assign rd = is_buy ? s_rd : b_rd;

  logic [BOOK_DEPTH-1:0] opp_v, own_v;
  assign opp_v = is_buy ? sv_r : bv_r;
  assign own_v = is_buy ? bv_r : sv_r;

  // Better-than compare for the entry arriving from RAM.
  logic better;
  always_comb begin
    if (!found_r) begin
      better = 1'b1;
    end else if (is_buy) begin
      better = (rd.price < best_e_r.price) ||
               (rd.price == best_e_r.price && rd.seq < best_e_r.seq);
    end else begin
      better = (rd.price > best_e_r.price) ||
               (rd.price == best_e_r.price && rd.seq < best_e_r.seq);
    end
  end

  // Lowest free slot of the order's own side.
  logic          free_found;
  logic [AW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!own_v[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  // Fill arithmetic on the registered best entry.
  logic        crosses;
  logic [15:0] q;
  logic [23:0] pdiff;
  logic [39:0] pb;
  logic [39:0] dval;
  logic [48:0] vsum;
  logic [64:0] xsum;
  assign crosses = is_buy ? (item_r.price >= best_e_r.price)
                          : (item_r.price <= best_e_r.price);
  assign q       = (left_r < best_e_r.qty) ? left_r : best_e_r.qty;
  assign pdiff   = is_buy ? (item_r.price - best_e_r.price) : (best_e_r.price - item_r.price);
  assign pb      = 40'(pdiff) * 40'(q);
  assign dval    = 40'(best_e_r.price) * 40'(q);
  assign vsum    = {1'b0, vol_r} + 49'(q);
  assign xsum    = {1'b0, val_r} + 65'(dval);

  // Decay product for the tick sweep.
  logic [32:0] dprod;
  logic [15:0] dq;
  assign dprod = 33'(s_rd.qty) * 33'(decay_r);
  assign dq    = dprod[31:16];

  logic [AW-1:0] idx_a;
  assign idx_a = idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    s_we  = 1'b0;
    b_we  = 1'b0;
    raddr = idx_a;
    waddr = best_r;
    wdata = best_e_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (in_item.kind == KIND_TICK) begin
            state_nxt = (decay_r >= DECAY_ONE) ? S_SUM : S_TICKR;
          end else if (in_item.kind == KIND_SKIP) begin
            state_nxt = S_IDLE;
          end else if (in_item.amount == 16'd0) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == CW'(BOOK_DEPTH)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // Wait for the last comparison to land.
        if (!cmp_act_r) state_nxt = S_RDB;
      end
      S_RDB: begin
        state_nxt = (found_r && left_r != 16'd0 && crosses) ? S_FILL : S_INS;
      end
      S_FILL: begin
        wdata.qty = best_e_r.qty - q;
        s_we = is_buy;
        b_we = !is_buy;
        state_nxt = (left_r == q) ? S_INS : S_SCAN;
      end
      S_INS: begin
        waddr = free_slot;
        wdata.price = item_r.price;
        wdata.seq   = seq_r;
        wdata.qty   = left_r;
        wdata.owner = item_r.trader_id;
        if (left_r != 16'd0 && free_found) begin
          s_we = !is_buy;
          b_we = is_buy;
        end
        state_nxt = S_SUM;
      end
      S_SUM: state_nxt = S_IDLE;
      S_TICKR: begin
        if (idx_r == CW'(BOOK_DEPTH)) state_nxt = S_SUM;
        else state_nxt = S_TICKW;
      end
      S_TICKW: begin
        waddr = idx_a;
        wdata = s_rd;
        wdata.qty = dq;
        s_we = sv_r[idx_a];
        state_nxt = S_TICKR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      decay_r   <= DECAY_ONE;
      counter_r <= '0;
      sv_r      <= '0;
      bv_r      <= '0;
      recent_r  <= '0;
      min_r     <= '1;
      max_r     <= '0;
      vol_r     <= '0;
      val_r     <= '0;
      out_valid <= 1'b0;
      cmp_act_r <= 1'b0;
      found_r   <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) decay_r <= cfg_wdata;
      // Comparison of the entry read last cycle.
      cmp_act_r <= (state_r == S_SCAN) && (idx_r != CW'(BOOK_DEPTH));
      cmp_idx_r <= idx_a;
      if (cmp_act_r && opp_v[cmp_idx_r] && better) begin
        found_r  <= 1'b1;
        best_r   <= cmp_idx_r;
        best_e_r <= rd;
      end
      unique case (state_r)
        S_IDLE: begin
          item_r     <= in_item;
          left_r     <= in_item.amount;
          idx_r      <= '0;
          found_r    <= 1'b0;
          sum_kind_r <= (in_item.kind == KIND_TICK) ? RES_TICK : RES_FILLED;
          if (start && (in_item.kind == KIND_SELL || in_item.kind == KIND_BUY)) begin
            if (in_item.precedence != 32'd0) begin
              seq_r <= in_item.precedence;
            end else begin
              seq_r     <= counter_r + 32'd1;
              counter_r <= counter_r + 32'd1;
            end
          end
        end
        S_SCAN: begin
          if (idx_r != CW'(BOOK_DEPTH)) idx_r <= idx_r + CW'(1);
        end
        S_EVAL, S_RDB: ;
        S_FILL: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          left_r  <= left_r - q;
          if (best_e_r.qty == q) begin
            if (is_buy) sv_r[best_r] <= 1'b0;
            else bv_r[best_r] <= 1'b0;
          end
          recent_r <= best_e_r.price;
          if (best_e_r.price > max_r) max_r <= best_e_r.price;
          if (best_e_r.price < min_r) min_r <= best_e_r.price;
          vol_r <= vsum[48] ? '1 : vsum[47:0];
          val_r <= xsum[64] ? '1 : xsum[63:0];
          out_valid <= 1'b1;
          res_r.result_kind <= RES_FILL;
          res_r.fill_price  <= best_e_r.price;
          res_r.fill_amount <= q;
          res_r.buy_trader  <= is_buy ? item_r.trader_id : best_e_r.owner;
          res_r.sell_trader <= is_buy ? best_e_r.owner : item_r.trader_id;
          res_r.payback     <= pb;
          res_r.last        <= 1'b0;
        end
        S_INS: begin
          if (left_r == 16'd0) begin
            sum_kind_r <= RES_FILLED;
          end else if (!free_found) begin
            sum_kind_r <= RES_DROPPED;
          end else begin
            sum_kind_r <= RES_RESTED;
            if (is_buy) bv_r[free_slot] <= 1'b1;
            else sv_r[free_slot] <= 1'b1;
          end
        end
        S_SUM: begin
          out_valid <= 1'b1;
          res_r.result_kind <= sum_kind_r;
          res_r.fill_price  <= '0;
          res_r.fill_amount <= (sum_kind_r == RES_TICK) ? 16'd0 : left_r;
          res_r.buy_trader  <= (sum_kind_r != RES_TICK && is_buy) ? item_r.trader_id : '0;
          res_r.sell_trader <= (sum_kind_r != RES_TICK && item_r.kind == KIND_SELL)
                               ? item_r.trader_id : '0;
          res_r.payback     <= '0;
          res_r.last        <= 1'b1;
        end
        S_TICKR: begin
          // Read address idx is issued this cycle.
        end
        S_TICKW: begin
          if (sv_r[idx_a] && dq == 16'd0) sv_r[idx_a] <= 1'b0;
          idx_r <= idx_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Statistics shown on every result reflect their own update.
  always_comb begin
    out_item = '{result_kind: res_r.result_kind, fill_price: res_r.fill_price,
                 fill_amount: res_r.fill_amount, buy_trader: res_r.buy_trader,
                 sell_trader: res_r.sell_trader, payback: res_r.payback,
                 last: res_r.last, recent_price: recent_r, low_price: min_r,
                 high_price: max_r, traded_volume: vol_r, traded_value: val_r};
  end
endmodule
`default_nettype wire

FILE: sv/lob_checker.sv
// Port-level checker for the limit order book matcher, bound to the top level.
// Depends on lob_pkg.
`default_nettype none
module lob_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire lob_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire lob_pkg::out_item_t out_item
);
  import lob_pkg::*;

  // An accepted order or tick makes the block busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.kind == KIND_SELL || in_item.kind == KIND_BUY ||
     in_item.kind == KIND_TICK)) |=> busy) else $error("not busy after accept");

  // A final result shows only once the block is free again.
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy) else $error("busy during last");

  // A fill result is never the last of a transaction.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.result_kind == RES_FILL) |-> !out_item.last)
    else $error("fill marked last");

  // Lowest deal price never exceeds highest once a deal happened.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.low_price != 24'hFFFFFF) |->
    out_item.low_price <= out_item.high_price) else $error("price range");
endmodule

bind limit_order_book_matcher lob_checker u_lob_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item));
`default_nettype wire

FILE: dv/lob_match_checker.sv
// Checker for the limit order book matcher: watches accepted orders, keeps its own
// book and statistics, and compares every emitted result. Depends on lob_pkg.
`timescale 1ns / 1ps
module lob_match_checker #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire lob_pkg::in_item_t  in_item,
  input  wire logic               out_valid,
  input  wire lob_pkg::out_item_t out_item,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_wdata,
  output int                      errors,
  output int                      pending,
  output int                      fills_seen
);
  import lob_pkg::*;

  typedef struct {
    logic        ok;
    logic [23:0] price;
    logic [31:0] seq;
    logic [15:0] qty;
    logic [9:0]  owner;
  } slot_t;

  slot_t       asks [DEPTH];
  slot_t       bids [DEPTH];
  logic [31:0] seq_ctr;
  logic [23:0] last_px, low_px, high_px;
  logic [47:0] vol_sum;
  logic [63:0] val_sum;
  logic [16:0] decay;
  out_item_t   due_q[$];

  function automatic logic better(slot_t a, slot_t b, bit buy_side);
    if (!b.ok) return 1'b1;
    if (a.price == b.price) return a.seq < b.seq;
    return buy_side ? (a.price > b.price) : (a.price < b.price);
  endfunction

  function automatic out_item_t stamp(logic [2:0] k, logic [23:0] p, logic [15:0] a,
                                      logic [9:0] bt, logic [9:0] st, logic [39:0] pb);
    out_item_t o;
    o = '{result_kind: k, fill_price: p, fill_amount: a, buy_trader: bt,
          sell_trader: st, payback: pb, last: 1'b0, recent_price: last_px,
          low_price: low_px, high_price: high_px, traded_volume: vol_sum,
          traded_value: val_sum};
    return o;
  endfunction

  task automatic book_deal(logic [23:0] px, logic [15:0] q);
    logic [63:0] v;
    v = 64'(px) * 64'(q);
    last_px = px;
    if (px > high_px) high_px = px;
    if (px < low_px) low_px = px;
    vol_sum = (48'hFFFF_FFFF_FFFF - vol_sum < 48'(q)) ? 48'hFFFF_FFFF_FFFF : vol_sum + q;
    val_sum = (64'hFFFF_FFFF_FFFF_FFFF - val_sum < v) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                      : val_sum + v;
  endtask

  task automatic match_order(in_item_t it);
    logic [31:0] sq;
    logic [15:0] left;
    logic [15:0] q;
    logic [2:0]  summ;
    out_item_t   o;
    int          b, slot;
    bit          is_buy;
    is_buy = (it.kind == KIND_BUY);
    left = it.amount;
    if (it.precedence != 0) sq = it.precedence;
    else begin
      seq_ctr = seq_ctr + 1;
      sq = seq_ctr;
    end
    forever begin
      b = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (is_buy) begin
          if (asks[i].ok && (b < 0 || better(asks[i], asks[b], 0))) b = i;
        end else begin
          if (bids[i].ok && (b < 0 || better(bids[i], bids[b], 1))) b = i;
        end
      end
      if (b < 0 || left == 0) break;
      if (is_buy) begin
        if (it.price < asks[b].price) break;
        q = (left < asks[b].qty) ? left : asks[b].qty;
        book_deal(asks[b].price, q);
        due_q = {due_q, stamp(RES_FILL, asks[b].price, q, it.trader_id, asks[b].owner,
                              40'(64'(it.price - asks[b].price) * q))};
        asks[b].qty -= q;
        if (asks[b].qty == 0) asks[b].ok = 1'b0;
      end else begin
        if (it.price > bids[b].price) break;
        q = (left < bids[b].qty) ? left : bids[b].qty;
        book_deal(bids[b].price, q);
        due_q = {due_q, stamp(RES_FILL, bids[b].price, q, bids[b].owner, it.trader_id,
                              40'(64'(bids[b].price - it.price) * q))};
        bids[b].qty -= q;
        if (bids[b].qty == 0) bids[b].ok = 1'b0;
      end
      left -= q;
    end
    if (left == 0) summ = RES_FILLED;
    else begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && !(is_buy ? bids[i].ok : asks[i].ok)) slot = i;
      if (slot < 0) summ = RES_DROPPED;
      else begin
        summ = RES_RESTED;
        if (is_buy) bids[slot] = '{1'b1, it.price, sq, left, it.trader_id};
        else asks[slot] = '{1'b1, it.price, sq, left, it.trader_id};
      end
    end
    o = stamp(summ, 24'd0, left, is_buy ? it.trader_id : 10'd0,
              is_buy ? 10'd0 : it.trader_id, 40'd0);
    o.last = 1'b1;
    due_q = {due_q, o};
  endtask

  task automatic apply_decay();
    logic [32:0] prod;
    out_item_t   o;
    if (decay < DECAY_ONE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (asks[i].ok) begin
          prod = 33'(asks[i].qty) * 33'(decay);
          asks[i].qty = prod[31:16];
          if (asks[i].qty == 0) asks[i].ok = 1'b0;
        end
      end
    end
    o = stamp(RES_TICK, 24'd0, 16'd0, 10'd0, 10'd0, 40'd0);
    o.last = 1'b1;
    due_q = {due_q, o};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        asks[i].ok = 1'b0;
        bids[i].ok = 1'b0;
      end
      seq_ctr = '0;
      last_px = '0;
      low_px = '1;
      high_px = '0;
      vol_sum = '0;
      val_sum = '0;
      decay = DECAY_ONE;
      due_q.delete();
      errors = 0;
      fills_seen = 0;
    end else begin
      // Results are checked before the input of this edge is folded in; an
      // order can never produce a result in the same cycle it is accepted.
      if (out_valid) begin
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %p", out_item);
        end else begin
          if (out_item !== due_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                       due_q[0], out_item);
          end
          if (due_q[0].result_kind == RES_FILL) fills_seen++;
          void'(due_q.pop_front());
        end
      end
      if (cfg_we) decay = cfg_wdata;
      if (start && !busy) begin
        if (in_item.kind == KIND_TICK) apply_decay();
        else if (in_item.kind == KIND_SELL || in_item.kind == KIND_BUY)
          match_order(in_item);
      end
    end
    pending = due_q.size();
  end
endmodule

FILE: dv/limit_order_book_matcher_tb.sv
// Top of the limit order book matcher testbench: clock, reset, order stimulus
// and verdict. Depends on lob_pkg, limit_order_book_matcher and lob_match_checker.
`timescale 1ns / 1ps
module limit_order_book_matcher_tb;
  import lob_pkg::*;

  localparam int DEPTH = 32;
  // Slowest order: 33 scans of DEPTH slots each, plus gaps.
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  int          errors, pending, fills_seen;
  int          cycles = 0;
  int          sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lob_match_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .fills_seen(fills_seen)
  );

  // The timeout watchdog runs on its own and ends the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("limit_order_book_matcher_tb: FAIL");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. The start
  // is dropped afterwards only when a gap follows, so it never toggles twice
  // in one time step.
  task automatic place(in_item_t it, bit keep_going);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (!keep_going) start <= 1'b0;
  endtask

  task automatic place_gap(in_item_t it);
    place(it, 1'b0);
    repeat ($urandom_range(0, 3)) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] k, logic [23:0] p, logic [15:0] a,
                                  logic [9:0] t, logic [31:0] pr);
    in_item_t it;
    it = '{kind: k, price: p, amount: a, trader_id: t, precedence: pr};
    return it;
  endfunction

  // Prices cluster in a narrow band so that buy and sell orders cross often.
  function automatic in_item_t rand_order();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.kind = (r < 46) ? KIND_SELL : (r < 92) ? KIND_BUY : (r < 97) ? KIND_TICK : KIND_SKIP;
    it.price = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'(1000 + $urandom_range(0, 40));
    it.amount = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    it.trader_id = 10'($urandom);
    it.precedence = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    return it;
  endfunction

  // Configuration is written only when the block is quiet; a tail of cycles
  // covers a trailing scan that has no result still pending.
  task automatic set_decay(logic [16:0] v);
    while (pending != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        place(rand_order(), burst > 1 && count > 1);
        burst--;
        count--;
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, zero amount, crossing orders, a sweep
    // across several levels, equal price and sequence ties, and ticks.
    place_gap(mk(KIND_SELL, 24'd0, 16'd0, 10'd0, 32'd0));
    place_gap(mk(KIND_SELL, 24'd500, 16'd100, 10'd1, 32'd0));
    place_gap(mk(KIND_SELL, 24'd500, 16'd50, 10'd2, 32'd0));
    place_gap(mk(KIND_SELL, 24'd400, 16'd30, 10'd3, 32'd7));
    place_gap(mk(KIND_SELL, 24'd400, 16'd30, 10'd4, 32'd7));
    place_gap(mk(KIND_BUY, 24'hFFFFFF, 16'd150, 10'h3FF, 32'hFFFFFFFF));
    place_gap(mk(KIND_BUY, 24'd10, 16'hFFFF, 10'd5, 32'd0));
    place_gap(mk(KIND_SELL, 24'd5, 16'd65535, 10'd6, 32'd0));
    place_gap(mk(KIND_SELL, 24'hFFFFFF, 16'hFFFF, 10'd7, 32'd0));
    place_gap(mk(KIND_BUY, 24'hFFFFFF, 16'hFFFF, 10'd8, 32'd0));
    place_gap(mk(KIND_BUY, 24'd0, 16'hFFFF, 10'd9, 32'd0));
    place_gap(mk(KIND_TICK, 24'hFFFFFF, 16'hFFFF, 10'h3FF, 32'hFFFFFFFF));
    place_gap(mk(KIND_SKIP, 24'hFFFFFF, 16'hFFFF, 10'h3FF, 32'hFFFFFFFF));
    place_gap(mk(KIND_SELL, 24'd20, 16'd1, 10'd10, 32'd0));
    place_gap(mk(KIND_SELL, 24'd20, 16'd3, 10'd11, 32'd0));

    // A decay of zero wipes the sell side; a half rate halves it.
    set_decay(17'd0);
    place_gap(mk(KIND_TICK, 24'd0, 16'd0, 10'd0, 32'd0));
    set_decay(17'd32768);
    place_gap(mk(KIND_SELL, 24'd30, 16'd9, 10'd12, 32'd0));
    place_gap(mk(KIND_TICK, 24'd0, 16'd0, 10'd0, 32'd0));
    place_gap(mk(KIND_BUY, 24'd30, 16'd4, 10'd13, 32'd0));

    // Fill the sell side to the brim so that later orders are dropped.
    set_decay(17'h1FFFF);
    for (int i = 0; i < DEPTH + 2; i++)
      place(mk(KIND_SELL, 24'(60000 + i), 16'd2, 10'(i), 32'd0), i < DEPTH + 1);
    start <= 1'b0;
    place_gap(mk(KIND_TICK, 24'd0, 16'd0, 10'd0, 32'd0));
    // One buy sweeps most of the full book in a single order.
    place_gap(mk(KIND_BUY, 24'd70000, 16'd60, 10'd77, 32'd0));

    // Random part across several decay settings, the extremes among them.
    set_decay(DECAY_ONE);
    random_phase(20);
    set_decay(17'd65535);
    random_phase(15);
    set_decay(17'd1);
    random_phase(15);
    set_decay(17'($urandom_range(0, 65536)));
    random_phase(15);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions with %0d fills checked over %0d cycles.",
             sent, fills_seen, cycles);
    if (errors == 0) $display("limit_order_book_matcher_tb: PASS");
    else $display("limit_order_book_matcher_tb: FAIL");
    $finish;
  end
endmodule

FILE: files.f
sv/lob_pkg.sv
sv/lob_ram.sv
sv/limit_order_book_matcher.sv
sv/lob_checker.sv
dv/lob_match_checker.sv
dv/limit_order_book_matcher_tb.sv
